[hw/rtl/ptt_pkg.sv]
// ----------------------------------------------------------------------------
// Periodic task timer table package
// Shared sizes, codes and the controller/datapath command and status types.
// ----------------------------------------------------------------------------
package ptt_pkg;

	localparam int TASK_SLOTS   = 16;
	localparam int TIME_BITS    = 48;
	localparam int ELAPSED_BITS = 16;

	localparam int SLOT_W  = $clog2(TASK_SLOTS);
	localparam int FRESH_W = SLOT_W + 1;
	localparam int CD_W    = 34;
	localparam int EL_W    = (ELAPSED_BITS < 16) ? ELAPSED_BITS : 16;

	// input actions
	localparam logic [2:0] ACT_TICK    = 3'd0;
	localparam logic [2:0] ACT_CREATE  = 3'd1;
	localparam logic [2:0] ACT_DELETE  = 3'd2;
	localparam logic [2:0] ACT_SUSPEND = 3'd3;
	localparam logic [2:0] ACT_RESUME  = 3'd4;

	// result kinds
	localparam logic [1:0] EV_ACK  = 2'd0;
	localparam logic [1:0] EV_DUE  = 2'd1;
	localparam logic [1:0] EV_IDLE = 2'd2;

	// result status
	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_EMPTY = 2'd2;

	// suspend modes
	localparam logic [1:0] MODE_RUN     = 2'd0;
	localparam logic [1:0] MODE_TIMED   = 2'd1;
	localparam logic [1:0] MODE_FOREVER = 2'd2;

	typedef struct packed {
		logic take_ok;    // input channel open
		logic cmd_exec;   // execute latched command and load its acknowledge
		logic walk_step;  // process the slot at the walk index
		logic report;     // load the idle report
	} ctl_t;

	typedef struct packed {
		logic req_valid;
		logic req_tick;
		logic out_free;
		logic walk_stall;
		logic walk_last;
	} sts_t;

endpackage

[hw/rtl/ptt_req_if.sv]
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one command or tick transaction.
// ----------------------------------------------------------------------------
interface ptt_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [3:0]  slot;
	logic [31:0] period;
	logic [31:0] first_delay;
	logic [31:0] delay;
	logic        forever_req;
	logic [15:0] elapsed;

	modport source (output valid, action, slot, period, first_delay, delay, forever_req,
		elapsed, input ready);
	modport sink (input valid, action, slot, period, first_delay, delay, forever_req,
		elapsed, output ready);
endinterface

[hw/rtl/ptt_rsp_if.sv]
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one acknowledge, due event or idle report.
// ----------------------------------------------------------------------------
interface ptt_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_kind;
	logic [3:0]  task_slot;
	logic [1:0]  status;
	logic [31:0] idle_ms;
	logic        last;

	modport source (output valid, event_kind, task_slot, status, idle_ms, last,
		input ready);
	modport sink (input valid, event_kind, task_slot, status, idle_ms, last,
		output ready);
endinterface

[hw/rtl/ptt_ctrl.sv]
// ----------------------------------------------------------------------------
// Periodic task timer controller
// Sequences command execution, the slot walk of a tick and the idle report.
// ----------------------------------------------------------------------------
module ptt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  ptt_pkg::sts_t sts,
	output ptt_pkg::ctl_t ctl
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CMD    = 3'd1;
	localparam logic [2:0] S_WALK   = 3'd2;
	localparam logic [2:0] S_DRAIN  = 3'd3;
	localparam logic [2:0] S_REPORT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		ctl       = '0;
		state_d   = state_q;
		unique case (state_q)
			S_IDLE: begin
				ctl.take_ok = 1'b1;
				if (sts.req_valid) begin
					state_d = sts.req_tick ? S_WALK : S_CMD;
				end
			end
			S_CMD: begin
				ctl.cmd_exec = sts.out_free;
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			S_WALK: begin
				ctl.walk_step = !sts.walk_stall;
				if (!sts.walk_stall && sts.walk_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// last slot's countdown enters the minimum here
				state_d = S_REPORT;
			end
			S_REPORT: begin
				ctl.report = sts.out_free;
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hw/rtl/ptt_dp.sv]
// ----------------------------------------------------------------------------
// Periodic task timer datapath
// Slot table, clock, walk arithmetic, running minimum and result register.
// ----------------------------------------------------------------------------
module ptt_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  ptt_pkg::ctl_t ctl,
	output ptt_pkg::sts_t sts,
	ptt_req_if.sink       req,
	ptt_rsp_if.source     rsp
);

	localparam int SW = ptt_pkg::SLOT_W;
	localparam int CW = ptt_pkg::CD_W;
	localparam int TW = ptt_pkg::TIME_BITS;
	localparam int EW = ptt_pkg::EL_W;

	// latched item
	logic [2:0]  act_q;
	logic [3:0]  slot_q;
	logic [31:0] period_q;
	logic [31:0] first_q;
	logic [31:0] delay_q;
	logic        forever_q;
	logic [EW-1:0] el_q;

	// slot table
	logic [ptt_pkg::TASK_SLOTS-1:0] used_q;
	logic [31:0]   per_mem_q  [ptt_pkg::TASK_SLOTS];
	logic [CW-1:0] cd_mem_q   [ptt_pkg::TASK_SLOTS];
	logic [1:0]    mode_mem_q [ptt_pkg::TASK_SLOTS];
	logic [TW-1:0] wake_mem_q [ptt_pkg::TASK_SLOTS];

	logic [TW-1:0]                cur_time_q;
	logic [ptt_pkg::FRESH_W-1:0]  nf_q;
	logic [SW-1:0]                walk_idx_q;
	logic [31:0]                  best_q;

	logic          valid_s1;
	logic          used_s1;
	logic [CW-1:0] cd_s1;

	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [3:0]  tslot_q;
	logic [1:0]  status_q;
	logic [31:0] idle_q;
	logic        last_q;

	logic accept;
	logic out_free;

	// command decode
	logic          slot_ok;
	logic [SW-1:0] cmd_idx;
	logic          addr_used;
	logic          fresh_avail;
	logic [SW-1:0] free_idx;
	logic          free_any;
	logic [SW-1:0] create_idx;
	logic          create_ok;

	// walk
	logic [31:0]   per_r;
	logic [CW-1:0] cd_r;
	logic [1:0]    mode_r;
	logic [TW-1:0] wake_r;
	logic          used_r;
	logic [1:0]    new_mode;
	logic [CW:0]   dec;
	logic          sat;
	logic [CW-1:0] sat_cd;
	logic          due;
	logic [CW-1:0] reload_cd;
	logic [CW-1:0] new_cd;
	logic          due_run;

	// table write port and result load
	logic          wr_en_per;
	logic          wr_en_cd;
	logic          wr_en_mode;
	logic          wr_en_wake;
	logic [SW-1:0] wr_idx;
	logic [CW-1:0] wr_cd;
	logic [1:0]    wr_mode;
	logic          set_used;
	logic          clr_used;
	logic          bump_fresh;
	logic          ld_out;
	logic [1:0]    ld_kind;
	logic [3:0]    ld_tslot;
	logic [1:0]    ld_status;
	logic [31:0]   ld_idle;
	logic          ld_last;

	assign accept    = req.valid && ctl.take_ok;
	assign req.ready = ctl.take_ok;
	assign out_free  = !out_valid_q || rsp.ready;

	// command decode
	assign slot_ok     = 32'(slot_q) < 32'(ptt_pkg::TASK_SLOTS);
	assign cmd_idx     = SW'(slot_q);
	assign addr_used   = slot_ok && used_q[cmd_idx];
	assign fresh_avail = nf_q < ptt_pkg::FRESH_W'(ptt_pkg::TASK_SLOTS);

	always_comb begin
		free_idx = '0;
		free_any = 1'b0;
		for (int i = ptt_pkg::TASK_SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_idx = SW'(i);
				free_any = 1'b1;
			end
		end
	end

	assign create_idx = fresh_avail ? SW'(nf_q) : free_idx;
	assign create_ok  = fresh_avail || free_any;

	// walk arithmetic on the slot at the walk index
	assign per_r  = per_mem_q[walk_idx_q];
	assign cd_r   = cd_mem_q[walk_idx_q];
	assign mode_r = mode_mem_q[walk_idx_q];
	assign wake_r = wake_mem_q[walk_idx_q];
	assign used_r = used_q[walk_idx_q];

	assign new_mode = (mode_r == ptt_pkg::MODE_TIMED && cur_time_q >= wake_r) ?
		ptt_pkg::MODE_RUN : mode_r;

	assign dec       = {cd_r[CW-1], cd_r} - {{(CW + 1 - EW){1'b0}}, el_q};
	assign sat       = dec[CW] & ~dec[CW-1];
	assign sat_cd    = sat ? {1'b1, {(CW - 1){1'b0}}} : dec[CW-1:0];
	assign due       = sat_cd[CW-1] || (sat_cd == '0);
	// floor plus period needs no adder: the floor has only its top bit set
	assign reload_cd = sat ? {2'b10, per_r} :
		(cd_r - {{(CW - EW){1'b0}}, el_q} + {2'b00, per_r});
	assign new_cd    = due ? reload_cd : sat_cd;
	assign due_run   = used_r && due && (new_mode == ptt_pkg::MODE_RUN);

	assign sts.req_valid  = req.valid;
	assign sts.req_tick   = req.action == ptt_pkg::ACT_TICK;
	assign sts.out_free   = out_free;
	assign sts.walk_stall = due_run && !out_free;
	assign sts.walk_last  = walk_idx_q == SW'(ptt_pkg::TASK_SLOTS - 1);

	always_comb begin
		wr_en_per  = 1'b0;
		wr_en_cd   = 1'b0;
		wr_en_mode = 1'b0;
		wr_en_wake = 1'b0;
		wr_idx     = cmd_idx;
		wr_cd      = new_cd;
		wr_mode    = new_mode;
		set_used   = 1'b0;
		clr_used   = 1'b0;
		bump_fresh = 1'b0;
		ld_out     = 1'b0;
		ld_kind    = ptt_pkg::EV_ACK;
		ld_tslot   = slot_q;
		ld_status  = ptt_pkg::STS_OK;
		ld_idle    = '0;
		ld_last    = 1'b1;
		if (ctl.walk_step) begin
			wr_idx     = walk_idx_q;
			wr_en_cd   = used_r;
			wr_en_mode = used_r;
			if (due_run) begin
				ld_out   = 1'b1;
				ld_kind  = ptt_pkg::EV_DUE;
				ld_tslot = 4'(walk_idx_q);
				ld_last  = 1'b0;
			end
		end else if (ctl.report) begin
			ld_out   = 1'b1;
			ld_kind  = ptt_pkg::EV_IDLE;
			ld_tslot = '0;
			ld_idle  = best_q;
		end else if (ctl.cmd_exec) begin
			ld_out = 1'b1;
			case (act_q) inside
				ptt_pkg::ACT_CREATE: begin
					if (create_ok) begin
						wr_idx     = create_idx;
						wr_en_per  = 1'b1;
						wr_en_cd   = 1'b1;
						wr_cd      = {2'b00, first_q};
						wr_en_mode = 1'b1;
						wr_mode    = ptt_pkg::MODE_FOREVER;
						set_used   = 1'b1;
						bump_fresh = fresh_avail;
						ld_tslot   = 4'(create_idx);
					end else begin
						ld_tslot  = '0;
						ld_status = ptt_pkg::STS_FULL;
					end
				end
				ptt_pkg::ACT_DELETE, ptt_pkg::ACT_SUSPEND, ptt_pkg::ACT_RESUME: begin
					if (!addr_used) begin
						ld_status = ptt_pkg::STS_EMPTY;
					end else if (act_q == ptt_pkg::ACT_DELETE) begin
						clr_used = 1'b1;
					end else if (act_q == ptt_pkg::ACT_SUSPEND) begin
						wr_en_mode = 1'b1;
						wr_mode    = forever_q ? ptt_pkg::MODE_FOREVER : ptt_pkg::MODE_TIMED;
						wr_en_wake = !forever_q;
					end else begin
						wr_en_mode = 1'b1;
						wr_mode    = ptt_pkg::MODE_RUN;
					end
				end
				default: begin
					// unknown action: echo the slot, change nothing
				end
			endcase
		end
	end

	// item latch and table storage
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q     <= req.action;
			slot_q    <= req.slot;
			period_q  <= req.period;
			first_q   <= req.first_delay;
			delay_q   <= req.delay;
			forever_q <= req.forever_req;
			el_q      <= EW'(req.elapsed);
		end
		if (wr_en_per) begin
			per_mem_q[wr_idx] <= period_q;
		end
		if (wr_en_cd) begin
			cd_mem_q[wr_idx] <= wr_cd;
		end
		if (wr_en_mode) begin
			mode_mem_q[wr_idx] <= wr_mode;
		end
		if (wr_en_wake) begin
			wake_mem_q[wr_idx] <= cur_time_q + {{(TW - 32){1'b0}}, delay_q};
		end
		used_s1 <= used_r;
		cd_s1   <= new_cd;
		if (ld_out) begin
			kind_q   <= ld_kind;
			tslot_q  <= ld_tslot;
			status_q <= ld_status;
			idle_q   <= ld_idle;
			last_q   <= ld_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			cur_time_q  <= '0;
			nf_q        <= '0;
			walk_idx_q  <= '0;
			best_q      <= '1;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				walk_idx_q <= '0;
				best_q     <= '1;
				if (req.action == ptt_pkg::ACT_TICK) begin
					cur_time_q <= cur_time_q + {{(TW - EW){1'b0}}, EW'(req.elapsed)};
				end
			end else begin
				if (ctl.walk_step) begin
					walk_idx_q <= walk_idx_q + SW'(1);
				end
				// fold the previous slot's countdown into the minimum
				if (valid_s1 && used_s1 && !cd_s1[CW-1] && cd_s1 != '0 &&
						cd_s1[31:0] < best_q) begin
					best_q <= cd_s1[31:0];
				end
			end
			valid_s1 <= ctl.walk_step;
			if (set_used) begin
				used_q[wr_idx] <= 1'b1;
			end
			if (clr_used) begin
				used_q[cmd_idx] <= 1'b0;
			end
			if (bump_fresh) begin
				nf_q <= nf_q + ptt_pkg::FRESH_W'(1);
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.event_kind = kind_q;
	assign rsp.task_slot  = tslot_q;
	assign rsp.status     = status_q;
	assign rsp.idle_ms    = idle_q;
	assign rsp.last       = last_q;

`ifndef SYNTHESIS
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		ld_out |-> out_free)
		else $error("result register overwritten while occupied");

	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nf_q <= ptt_pkg::FRESH_W'(ptt_pkg::TASK_SLOTS))
		else $error("fresh slot counter beyond table size");

	a_walk_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (walk_idx_q == '0 && best_q == '1))
		else $error("walk not restarted on accepted transaction");

	a_idle_report: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.event_kind == ptt_pkg::EV_IDLE) |-> (rsp.last && rsp.task_slot == '0))
		else $error("idle report not final or carries a slot");

	a_ack_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.event_kind != ptt_pkg::EV_IDLE) |->
		(rsp.last == (rsp.event_kind == ptt_pkg::EV_ACK)))
		else $error("last flag does not match result kind");
`endif

endmodule

[hw/rtl/periodic_task_timer_table_top.sv]
// ----------------------------------------------------------------------------
// Periodic task timer table
// Task slot table with create/delete/suspend/resume commands and tick walk.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one transaction per command or tick (valid/ready). rsp returns
//   results (valid/ready); the final result of each transaction has last set.
//   Commands (create, delete, suspend, resume, unknown) give one acknowledge:
//   the command is accepted, then executed once the result register is free.
//   A tick walks every slot, one slot per cycle through the single table read
//   port while no due event waits on a stalled rsp, emitting a due event for
//   each running slot that comes due, then an idle report with the least
//   positive countdown (all ones when none). A tick is accepted, walks the
//   slots, folds the last countdown into the minimum in a drain step, then
//   loads the idle report.
//   When rsp stalls, a due event waits in the result register and the walk
//   holds on the next due slot until the register drains; req stays closed
//   until the current transaction has loaded its final result.
//   Reset (arst_n low) empties the table and zeroes the clock; slot contents
//   are written by create before use.
// ----------------------------------------------------------------------------
module periodic_task_timer_table_top (
	input  logic      clk,
	input  logic      arst_n,
	ptt_req_if.sink   req,
	ptt_rsp_if.source rsp
);

	ptt_pkg::ctl_t ctl;
	ptt_pkg::sts_t sts;

	ptt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	ptt_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sts    (sts),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

[sim/tb_periodic_task_timer_table_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task timer table testbench
// Drives create, delete, suspend, resume, unknown and tick transactions into
// the table, keeps its own copy of the slot table to work out every ack, due
// event and idle report, and compares each result in order. Both channels idle
// at random; one phase holds the result side off to back up the request side.
// ----------------------------------------------------------------------------
module tb_periodic_task_timer_table_top;

	localparam int     CYCLE_LIMIT = 1_000_000;
	localparam int     TAIL_CYCLES = 40;
	localparam int     HOLD_CYCLES = 300;
	localparam int     MAX_PRINT   = 30;
	localparam longint COUNT_FLOOR = -(longint'(1) << (ptt_pkg::CD_W - 1));

	typedef struct {
		logic [2:0]  action;
		logic [3:0]  slot;
		logic [31:0] period;
		logic [31:0] first_delay;
		logic [31:0] delay;
		logic        forever_req;
		logic [15:0] elapsed;
	} cmd_t;

	typedef struct {
		logic [1:0]  event_kind;
		logic [3:0]  task_slot;
		logic [1:0]  status;
		logic [31:0] idle_ms;
		logic        last;
	} timer_evt_t;

	logic clk;
	logic arst_n;

	ptt_req_if req_ch ();
	ptt_rsp_if rsp_ch ();

	periodic_task_timer_table_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow copy of the slot table
	bit                          tbl_used   [ptt_pkg::TASK_SLOTS];
	bit [31:0]                   tbl_period [ptt_pkg::TASK_SLOTS];
	longint                      tbl_count  [ptt_pkg::TASK_SLOTS];
	logic [1:0]                  tbl_mode   [ptt_pkg::TASK_SLOTS];
	bit [ptt_pkg::TIME_BITS-1:0] tbl_wake   [ptt_pkg::TASK_SLOTS];
	bit [ptt_pkg::TIME_BITS-1:0] clock_ms;
	int unsigned                 fresh_idx;

	timer_evt_t expected_events[$];

	int err_cnt;
	int sent_cnt;
	int tick_cnt;
	int due_cnt;
	int full_cnt;
	int result_cnt;
	int cycle_cnt;
	int req_idle_pct;
	int rsp_idle_pct;
	int rsp_hold_req;
	int rsp_hold_left;
	int rsp_stall_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap(input int pct);
		if ($urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic void push_expect(input logic [1:0] kind, input logic [3:0] slot,
		input logic [1:0] status, input logic [31:0] idle, input logic last);
		timer_evt_t ev;
		ev.event_kind = kind;
		ev.task_slot  = slot;
		ev.status     = status;
		ev.idle_ms    = idle;
		ev.last       = last;
		expected_events.push_back(ev);
	endfunction

	// advance the shadow table by one accepted transaction
	function automatic void table_step(input cmd_t c);
		longint el;
		longint best;
		int     s;
		bit     hit;
		if (c.action == ptt_pkg::ACT_TICK) begin
			el       = longint'(c.elapsed[ptt_pkg::EL_W-1:0]);
			clock_ms = clock_ms + c.elapsed[ptt_pkg::EL_W-1:0];
			best     = longint'(32'hFFFF_FFFF);
			tick_cnt++;
			for (int i = 0; i < ptt_pkg::TASK_SLOTS; i++) begin
				if (!tbl_used[i])
					continue;
				if (tbl_mode[i] == ptt_pkg::MODE_TIMED && clock_ms >= tbl_wake[i])
					tbl_mode[i] = ptt_pkg::MODE_RUN;
				tbl_count[i] -= el;
				if (tbl_count[i] < COUNT_FLOOR)
					tbl_count[i] = COUNT_FLOOR;
				if (tbl_count[i] <= 0) begin
					tbl_count[i] += longint'(tbl_period[i]);
					if (tbl_mode[i] == ptt_pkg::MODE_RUN) begin
						push_expect(ptt_pkg::EV_DUE, 4'(i), ptt_pkg::STS_OK, '0, 1'b0);
						due_cnt++;
					end
				end
			end
			for (int i = 0; i < ptt_pkg::TASK_SLOTS; i++) begin
				if (tbl_used[i] && tbl_count[i] > 0 && tbl_count[i] < best)
					best = tbl_count[i];
			end
			push_expect(ptt_pkg::EV_IDLE, '0, ptt_pkg::STS_OK, 32'(best), 1'b1);
		end else if (c.action == ptt_pkg::ACT_CREATE) begin
			hit = 1'b0;
			s   = 0;
			if (fresh_idx < ptt_pkg::TASK_SLOTS) begin
				s   = fresh_idx;
				hit = 1'b1;
				fresh_idx++;
			end else begin
				// scan downward so the lowest free slot wins
				for (int i = ptt_pkg::TASK_SLOTS - 1; i >= 0; i--) begin
					if (!tbl_used[i]) begin
						s   = i;
						hit = 1'b1;
					end
				end
			end
			if (!hit) begin
				push_expect(ptt_pkg::EV_ACK, '0, ptt_pkg::STS_FULL, '0, 1'b1);
				full_cnt++;
			end else begin
				tbl_used[s]   = 1'b1;
				tbl_period[s] = c.period;
				tbl_count[s]  = longint'(c.first_delay);
				tbl_mode[s]   = ptt_pkg::MODE_FOREVER;
				tbl_wake[s]   = '0;
				push_expect(ptt_pkg::EV_ACK, 4'(s), ptt_pkg::STS_OK, '0, 1'b1);
			end
		end else if (c.action >= ptt_pkg::ACT_DELETE && c.action <= ptt_pkg::ACT_RESUME) begin
			if (int'(c.slot) >= ptt_pkg::TASK_SLOTS || !tbl_used[c.slot]) begin
				push_expect(ptt_pkg::EV_ACK, c.slot, ptt_pkg::STS_EMPTY, '0, 1'b1);
			end else begin
				case (c.action)
					ptt_pkg::ACT_DELETE: begin
						tbl_used[c.slot] = 1'b0;
					end
					ptt_pkg::ACT_SUSPEND: begin
						if (c.forever_req) begin
							tbl_mode[c.slot] = ptt_pkg::MODE_FOREVER;
						end else begin
							tbl_mode[c.slot] = ptt_pkg::MODE_TIMED;
							tbl_wake[c.slot] = clock_ms + c.delay;
						end
					end
					default: begin
						tbl_mode[c.slot] = ptt_pkg::MODE_RUN;
					end
				endcase
				push_expect(ptt_pkg::EV_ACK, c.slot, ptt_pkg::STS_OK, '0, 1'b1);
			end
		end else begin
			push_expect(ptt_pkg::EV_ACK, c.slot, ptt_pkg::STS_OK, '0, 1'b1);
		end
	endfunction

	function automatic cmd_t mk_cmd(input logic [2:0] action, input logic [3:0] slot,
		input logic [31:0] period, input logic [31:0] first_delay, input logic [31:0] delay,
		input logic forever_req, input logic [15:0] elapsed);
		cmd_t c;
		c.action      = action;
		c.slot        = slot;
		c.period      = period;
		c.first_delay = first_delay;
		c.delay       = delay;
		c.forever_req = forever_req;
		c.elapsed     = elapsed;
		return c;
	endfunction

	function automatic cmd_t tick_cmd(input logic [15:0] elapsed);
		return mk_cmd(ptt_pkg::ACT_TICK, '0, '0, '0, '0, 1'b0, elapsed);
	endfunction

	// mostly short periods and steps so tasks come due often
	function automatic logic [31:0] pick_ms(input int short_max);
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, short_max);
		if (r < 90)
			return '0;
		return $urandom;
	endfunction

	function automatic logic [3:0] pick_slot();
		int used_q[$];
		for (int i = 0; i < ptt_pkg::TASK_SLOTS; i++)
			if (tbl_used[i])
				used_q.push_back(i);
		if (used_q.size() > 0 && $urandom_range(0, 99) < 80)
			return 4'(used_q[$urandom_range(0, used_q.size() - 1)]);
		return 4'($urandom_range(0, 15));
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t c;
		int   r;
		r = $urandom_range(0, 99);
		if (r < 40)
			c.action = ptt_pkg::ACT_TICK;
		else if (r < 55)
			c.action = ptt_pkg::ACT_CREATE;
		else if (r < 63)
			c.action = ptt_pkg::ACT_DELETE;
		else if (r < 76)
			c.action = ptt_pkg::ACT_SUSPEND;
		else if (r < 93)
			c.action = ptt_pkg::ACT_RESUME;
		else
			c.action = 3'($urandom_range(int'(ptt_pkg::ACT_RESUME) + 1, 7));
		c.slot        = pick_slot();
		c.period      = pick_ms(1000);
		c.first_delay = pick_ms(1500);
		c.delay       = ($urandom_range(0, 99) < 70) ? 32'($urandom_range(0, 2000)) : $urandom;
		c.forever_req = ($urandom_range(0, 99) < 30);
		c.elapsed     = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 400)) :
			16'($urandom);
		return c;
	endfunction

	// offer one transaction, hold it until taken, then maybe idle
	task automatic send_cmd(input cmd_t c);
		int gap;
		req_ch.valid       <= 1'b1;
		req_ch.action      <= c.action;
		req_ch.slot        <= c.slot;
		req_ch.period      <= c.period;
		req_ch.first_delay <= c.first_delay;
		req_ch.delay       <= c.delay;
		req_ch.forever_req <= c.forever_req;
		req_ch.elapsed     <= c.elapsed;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		table_step(c);
		sent_cnt++;
		gap = pick_gap(req_idle_pct);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drain();
		req_ch.valid <= 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_table();
		send_cmd(tick_cmd('0));
		send_cmd(mk_cmd(ptt_pkg::ACT_DELETE, 4'd0, '0, '0, '0, 1'b0, '0));
		send_cmd(mk_cmd(ptt_pkg::ACT_SUSPEND, 4'd15, '0, '0, '1, 1'b1, '0));
		send_cmd(mk_cmd(ptt_pkg::ACT_RESUME, 4'd7, '0, '0, '0, 1'b0, '0));
		for (int a = int'(ptt_pkg::ACT_RESUME) + 1; a < 8; a++)
			send_cmd(mk_cmd(3'(a), 4'(a * 5), '1, '1, '1, 1'b1, '1));
		wait_drain();
	endtask

	task automatic test_create_and_run();
		send_cmd(mk_cmd(ptt_pkg::ACT_CREATE, '0, '0, '0, '0, 1'b0, '0));
		send_cmd(mk_cmd(ptt_pkg::ACT_CREATE, '0, '1, '1, '0, 1'b0, '0));
		send_cmd(mk_cmd(ptt_pkg::ACT_CREATE, '0, 32'd100, 32'd50, '0, 1'b0, '0));
		// a new task stays quiet until resumed, but its countdown still runs
		send_cmd(tick_cmd(16'd20));
		send_cmd(mk_cmd(ptt_pkg::ACT_RESUME, 4'd0, '0, '0, '0, 1'b0, '0));
		send_cmd(mk_cmd(ptt_pkg::ACT_RESUME, 4'd2, '0, '0, '0, 1'b0, '0));
		send_cmd(tick_cmd(16'd60));
		// zero-length timed suspend wakes on the next tick
		send_cmd(mk_cmd(ptt_pkg::ACT_SUSPEND, 4'd2, '0, '0, '0, 1'b0, '0));
		send_cmd(mk_cmd(ptt_pkg::ACT_SUSPEND, 4'd0, '0, '0, '0, 1'b1, '0));
		send_cmd(tick_cmd('1));
		wait_drain();
	endtask

	task automatic test_table_full();
		while (fresh_idx < ptt_pkg::TASK_SLOTS)
			send_cmd(mk_cmd(ptt_pkg::ACT_CREATE, '0, 32'($urandom_range(1, 300)),
				32'($urandom_range(1, 300)), '0, 1'b0, '0));
		send_cmd(mk_cmd(ptt_pkg::ACT_CREATE, '0, '1, '1, '0, 1'b0, '0));
		send_cmd(mk_cmd(ptt_pkg::ACT_DELETE, 4'd4, '0, '0, '0, 1'b0, '0));
		send_cmd(mk_cmd(ptt_pkg::ACT_CREATE, '0, 32'd77, 32'd10, '0, 1'b0, '0));
		wait_drain();
	endtask

	task automatic test_random_traffic(input int n, input int req_pct, input int rsp_pct);
		req_idle_pct = req_pct;
		rsp_idle_pct = rsp_pct;
		repeat (n)
			send_cmd(random_cmd());
		wait_drain();
	endtask

	// block the result side while ticks keep arriving, so the request side backs up
	task automatic test_backpressure();
		req_idle_pct = 0;
		rsp_idle_pct = 0;
		for (int i = 0; i < ptt_pkg::TASK_SLOTS; i++)
			if (tbl_used[i] && $urandom_range(0, 1))
				send_cmd(mk_cmd(ptt_pkg::ACT_RESUME, 4'(i), '0, '0, '0, 1'b0, '0));
		rsp_hold_req = HOLD_CYCLES;
		repeat (10)
			send_cmd(tick_cmd(16'($urandom_range(50, 300))));
		wait_drain();
	endtask

	// result side: random stalls plus an optional long hold
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_hold_req != 0) begin
				rsp_hold_left = rsp_hold_req;
				rsp_hold_req  = 0;
			end
			if (rsp_hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				rsp_hold_left--;
			end else if (rsp_stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				rsp_stall_left--;
			end else begin
				rsp_stall_left = pick_gap(rsp_idle_pct);
				if (rsp_stall_left > 0) begin
					rsp_ch.ready <= 1'b0;
					rsp_stall_left--;
				end else begin
					rsp_ch.ready <= 1'b1;
				end
			end
		end
	end

	function automatic void check_field(input string fname, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			err_cnt++;
			if (err_cnt <= MAX_PRINT)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, exp_v,
					act_v);
		end
	endfunction

	always @(posedge clk) begin
		timer_evt_t exp_ev;
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			result_cnt++;
			if (expected_events.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_PRINT)
					$display("%0t: unexpected result, expected none, actual kind %0d slot %0d",
						$time, rsp_ch.event_kind, rsp_ch.task_slot);
			end else begin
				exp_ev = expected_events.pop_front();
				check_field("event_kind", exp_ev.event_kind, rsp_ch.event_kind);
				check_field("task_slot", exp_ev.task_slot, rsp_ch.task_slot);
				check_field("status", exp_ev.status, rsp_ch.status);
				check_field("idle_ms", exp_ev.idle_ms, rsp_ch.idle_ms);
				check_field("last", exp_ev.last, rsp_ch.last);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
				cycle_cnt, expected_events.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n             <= 1'b0;
		req_ch.valid       <= 1'b0;
		req_ch.action      <= ptt_pkg::ACT_TICK;
		req_ch.slot        <= '0;
		req_ch.period      <= '0;
		req_ch.first_delay <= '0;
		req_ch.delay       <= '0;
		req_ch.forever_req <= 1'b0;
		req_ch.elapsed     <= '0;
		req_idle_pct = 25;
		rsp_idle_pct = 25;
		clock_ms     = '0;
		fresh_idx    = 0;
		foreach (tbl_used[i])
			tbl_used[i] = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_create_and_run();
		test_table_full();
		test_random_traffic(65, 30, 30);
		test_backpressure();
		test_random_traffic(60, 0, 0);
		test_random_traffic(65, 40, 50);

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered all commands, empty-slot and full acks, timed and forever suspends");
		$display("%0d transactions (%0d ticks), %0d results checked, %0d due, %0d table full",
			sent_cnt, tick_cnt, result_cnt, due_cnt, full_cnt);
		if (err_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/ptt_pkg.sv
hw/rtl/ptt_req_if.sv
hw/rtl/ptt_rsp_if.sv
hw/rtl/ptt_ctrl.sv
hw/rtl/ptt_dp.sv
hw/rtl/periodic_task_timer_table_top.sv
sim/tb_periodic_task_timer_table_top.sv
